### hdl/axis_calibrate_and_percent_scale_unit_macros.svh
// assertion helpers shared by the rtl files
`ifndef AXIS_CALIBRATE_AND_PERCENT_SCALE_UNIT_MACROS_SVH
`define AXIS_CALIBRATE_AND_PERCENT_SCALE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked only outside reset
`define ACPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define ACPS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ACPS_ASSERT(lbl, prop, msg)
`define ACPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hdl/acps_pkg.sv
package acps_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int AXIS_COUNT_DEF = 2;

	// percent result and bit-serial quotient
	localparam int PCT_BITS = 7;
	localparam int DIV_STEPS = PCT_BITS;
	localparam logic [PCT_BITS-1:0] PCT_FULL = 7'd100;
	localparam logic [PCT_BITS-1:0] PCT_ZERO = 7'd0;

	// bound defaults, x and y alternate over further axes
	localparam logic [15:0] MIN_DEFAULT [4] = '{16'd820, 16'd739, 16'd820, 16'd739};
	localparam logic [15:0] MAX_DEFAULT [4] = '{16'd3101, 16'd3100, 16'd3101, 16'd3100};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CAL,
		ST_SETUP,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

### hdl/acps_div.sv
module acps_div #(
	parameter int SAMPLE_BITS = acps_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	input  logic [SAMPLE_BITS+acps_pkg::PCT_BITS-1:0] dividend,
	input  logic [SAMPLE_BITS-1:0]                    divisor,
	output logic                                      done,
	output logic [acps_pkg::PCT_BITS-1:0]             quotient
);

	localparam int PB = acps_pkg::PCT_BITS;
	localparam int CNT_W = $clog2(acps_pkg::DIV_STEPS + 1);

	logic [SAMPLE_BITS-1:0] rem_q;
	logic [SAMPLE_BITS-1:0] den_q;
	logic [PB-1:0]          num_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [SAMPLE_BITS:0]   trial;
	logic [SAMPLE_BITS:0]   diff;
	logic                   take;

	// restoring step: one quotient bit per cycle, shifted into the dividend register
	always_comb begin
		trial = {rem_q, num_q[PB-1]};
		diff  = trial - {1'b0, den_q};
		take  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(acps_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[SAMPLE_BITS+PB-1:PB];
			num_q <= dividend[PB-1:0];
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
			num_q <= {num_q[PB-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

### hdl/axis_calibrate_and_percent_scale_unit.sv
// joystick axis calibration and percent scaling
//
// input channel s_*: one converter sample per item, axis select in s_tuser.
// output channel m_*: one result item per input item, in input order.
// config channel cfg_*: the calibrating flag, always ready; write it only
// while no item is in flight. while set, a sample outside the stored bounds
// of its axis widens them before the position is computed.
//
// sequence: an accepted item passes the calibrate, setup and multiply states,
// then the 7 bit bit-serial divider (one quotient bit per cycle) unless the
// result saturates or the range is empty, then the result load. one item is
// in flight at a time: the next is accepted once the last result is loaded.
// stall: a finished item waits in the output register; the next item is
// accepted meanwhile and holds before its result load until m_tready frees
// the register.
// reset: bounds return to their defaults (x 820..3101, y 739..3100, cut to
// SAMPLE_BITS), calibrating clears, both channels go empty.
module axis_calibrate_and_percent_scale_unit #(
	parameter int SAMPLE_BITS = acps_pkg::SAMPLE_BITS_DEF,
	parameter int AXIS_COUNT  = acps_pkg::AXIS_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_data,     // calibrating
	// sample input
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,      // sample
	input  logic                                s_tuser,      // axis
	// position output
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [7:0]                          m_tdata,      // percent, zero pad
	output logic [1:0]                          m_tuser       // range_empty, axis_out
);

`include "axis_calibrate_and_percent_scale_unit_macros.svh"

	localparam int PB = acps_pkg::PCT_BITS;
	localparam int IDX_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
	localparam int PROD_W = SAMPLE_BITS + PB;

	acps_pkg::state_t state_q, state_d;

	// per axis calibrated bounds
	logic [SAMPLE_BITS-1:0] min_q [AXIS_COUNT];
	logic [SAMPLE_BITS-1:0] max_q [AXIS_COUNT];
	logic                   calibrating_q;

	// item in flight
	logic [IDX_W-1:0]       idx_q;
	logic                   axis_bit_q;
	logic [SAMPLE_BITS-1:0] smp_q;
	logic [SAMPLE_BITS-1:0] lo_q;
	logic [SAMPLE_BITS-1:0] hi_q;
	logic [SAMPLE_BITS-1:0] dist_q;
	logic [SAMPLE_BITS-1:0] span_q;
	logic                   empty_q;
	logic                   below_q;
	logic                   above_q;
	logic [PB-1:0]          res_q;

	// output register
	logic                   m_tvalid_q;
	logic [PB-1:0]          pct_out_q;
	logic                   axis_out_q;
	logic                   empty_out_q;

	logic                   accept;
	logic                   out_free;
	logic                   special;
	logic                   div_start;
	logic                   div_done;
	logic                   out_load;
	logic [PB-1:0]          quotient;
	logic [IDX_W-1:0]       idx_in;
	logic [SAMPLE_BITS-1:0] cur_lo;
	logic [SAMPLE_BITS-1:0] cur_hi;
	logic [SAMPLE_BITS-1:0] new_lo;
	logic [SAMPLE_BITS-1:0] new_hi;
	logic [PROD_W-1:0]      dist_ext;
	logic [PROD_W-1:0]      prod;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign special  = empty_q || below_q || above_q;

	// an axis index past the last axis falls back to the last one
	assign idx_in = (AXIS_COUNT > 1) ? IDX_W'(s_tuser) : '0;

	// widen bounds while calibrating
	always_comb begin
		cur_lo = min_q[idx_q];
		cur_hi = max_q[idx_q];
		new_lo = (calibrating_q && (smp_q < cur_lo)) ? smp_q : cur_lo;
		new_hi = (calibrating_q && (smp_q > cur_hi)) ? smp_q : cur_hi;
	end

	// times 100 as 64 + 32 + 4
	always_comb begin
		dist_ext = PROD_W'(dist_q);
		prod     = (dist_ext << 6) + (dist_ext << 5) + (dist_ext << 2);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			acps_pkg::ST_IDLE:  if (s_tvalid) state_d = acps_pkg::ST_CAL;
			acps_pkg::ST_CAL:   state_d = acps_pkg::ST_SETUP;
			acps_pkg::ST_SETUP: state_d = acps_pkg::ST_MUL;
			acps_pkg::ST_MUL:   state_d = special ? acps_pkg::ST_DONE : acps_pkg::ST_DIV;
			acps_pkg::ST_DIV:   if (div_done) state_d = acps_pkg::ST_DONE;
			acps_pkg::ST_DONE:  if (out_free) state_d = acps_pkg::ST_IDLE;
			default:            state_d = acps_pkg::ST_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			acps_pkg::ST_IDLE: s_tready = 1'b1;
			acps_pkg::ST_MUL:  div_start = !special;
			acps_pkg::ST_DONE: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= acps_pkg::ST_IDLE;
			calibrating_q <= 1'b0;
			m_tvalid_q    <= 1'b0;
			for (int i = 0; i < AXIS_COUNT; i++) begin
				min_q[i] <= acps_pkg::MIN_DEFAULT[i][SAMPLE_BITS-1:0];
				max_q[i] <= acps_pkg::MAX_DEFAULT[i][SAMPLE_BITS-1:0];
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				calibrating_q <= cfg_data;
			end
			if (state_q == acps_pkg::ST_CAL) begin
				min_q[idx_q] <= new_lo;
				max_q[idx_q] <= new_hi;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q      <= idx_in;
			axis_bit_q <= s_tuser;
			smp_q      <= s_tdata[SAMPLE_BITS-1:0];
		end
		if (state_q == acps_pkg::ST_CAL) begin
			lo_q <= new_lo;
			hi_q <= new_hi;
		end
		if (state_q == acps_pkg::ST_SETUP) begin
			empty_q <= (hi_q <= lo_q);
			below_q <= (smp_q <= lo_q);
			above_q <= (smp_q >= hi_q);
			dist_q  <= smp_q - lo_q;
			span_q  <= hi_q - lo_q;
		end
		if (state_q == acps_pkg::ST_MUL) begin
			res_q <= (above_q && !empty_q && !below_q) ? acps_pkg::PCT_FULL : acps_pkg::PCT_ZERO;
		end
		if ((state_q == acps_pkg::ST_DIV) && div_done) begin
			res_q <= quotient;
		end
		if (out_load) begin
			pct_out_q   <= res_q;
			axis_out_q  <= axis_bit_q;
			empty_out_q <= empty_q;
		end
	end

	acps_div #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (span_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {{(8 - PB){1'b0}}, pct_out_q};
	assign m_tuser   = {empty_out_q, axis_out_q};

	`ACPS_ASSERT(a_pct_range, m_tvalid_q |-> (pct_out_q <= acps_pkg::PCT_FULL), "percent above 100")
	`ACPS_ASSERT(a_empty_zero, (m_tvalid_q && empty_out_q) |-> (pct_out_q == acps_pkg::PCT_ZERO), "empty range with nonzero percent")
	`ACPS_ASSERT(a_accept_cal, accept |=> (state_q == acps_pkg::ST_CAL), "accepted item did not enter calibration")
	`ACPS_ASSERT(a_div_owner, div_done |-> (state_q == acps_pkg::ST_DIV), "divider finished outside divide state")
	`ACPS_ASSERT_ALWAYS(a_load_free, out_load |-> out_free, "result loaded over a pending item")

endmodule
